### sv/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg: shared types and constants for the Reed-Solomon encoder
// Register map, datapath op codes and the controller/datapath structs.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int SYMBOL_BITS_DEF = 8;
  localparam int MAX_PARITY_DEF  = 32;

  localparam int SYM_W    = 8;   // data and parity port width
  localparam int POLY_W   = 9;
  localparam int IDX_W    = 3;
  localparam int CNT_W    = 8;
  localparam int ROOT_W   = 7;   // holds up to 127 roots
  localparam int LEN_W    = 8;
  localparam int EXP_W    = 8;   // exponent register width

  localparam logic [IDX_W-1:0] REG_FIELD_POLY = 3'd0;
  localparam logic [IDX_W-1:0] REG_FIRST_ROOT = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROOT_STEP  = 3'd2;
  localparam logic [IDX_W-1:0] REG_PARITY_CNT = 3'd3;
  localparam logic [IDX_W-1:0] REG_PAD_CNT    = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT,
    OP_POW,
    OP_POW_MID,
    OP_GEN_SET,
    OP_GEN,
    OP_ABSORB,
    OP_SHIFT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic              cfg_hit;
    logic [ROOT_W-1:0] eff_roots;
    logic [LEN_W-1:0]  eff_len;
  } dp_status_t;

endpackage

### sv/rse_datapath.sv
// ----------------------------------------------------------------------------
// rse_datapath: registers and GF arithmetic of the Reed-Solomon encoder
// Config registers, exponentiation unit, generator build and parity LFSR.
// ----------------------------------------------------------------------------
module rse_datapath
  import rse_pkg::*;
#(
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
  parameter int MAX_PARITY  = MAX_PARITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [POLY_W-1:0] cfg_data,
  input  logic [SYM_W-1:0]  data_symbol,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  output logic [SYM_W-1:0]  parity_symbol
);

  localparam int M    = SYMBOL_BITS;
  localparam int NN   = (1 << M) - 1;
  localparam int MAXR = (MAX_PARITY < NN - 1) ? MAX_PARITY : NN - 1;
  localparam int L    = MAX_PARITY;

  function automatic logic [M-1:0] gf_mul(input logic [M-1:0] a, input logic [M-1:0] b,
                                          input logic [M-1:0] poly);
    logic [M-1:0] acc;
    acc = '0;
    for (int i = M - 1; i >= 0; i--) begin
      acc = {acc[M-2:0], 1'b0} ^ (acc[M-1] ? poly : '0);
      if (b[i]) acc = acc ^ a;
    end
    return acc;
  endfunction

  logic [POLY_W-1:0] field_poly;
  logic [EXP_W-1:0]  first_root;
  logic [EXP_W-1:0]  root_step;
  logic [5:0]        parity_count;
  logic [7:0]        pad_count;

  logic [ROOT_W-1:0] eff_roots;
  logic [LEN_W-1:0]  eff_len;

  logic [M-1:0]      pow_base;
  logic [M-1:0]      pow_acc;
  logic [EXP_W-1:0]  pow_exp;
  logic [M-1:0]      step_val;
  logic [M-1:0]      root_val;

  logic [M-1:0]      gen [L];   // reversed generator, leading one implied
  logic [M-1:0]      par [L];

  logic [M-1:0]      poly;
  logic [M-1:0]      fb;
  logic [ROOT_W-1:0] r_calc;
  logic [9:0]        pad_lim;
  logic [9:0]        pad_calc;
  logic [9:0]        len_calc;
  logic              cfg_hit;

  assign poly = field_poly[M-1:0];
  assign fb   = data_symbol[M-1:0] ^ par[0];

  always_comb begin
    if (parity_count == '0) begin
      r_calc = ROOT_W'(1);
    end else if (int'(parity_count) > MAXR) begin
      r_calc = ROOT_W'(MAXR);
    end else begin
      r_calc = ROOT_W'(parity_count);
    end
    pad_lim  = 10'(NN) - 10'(r_calc) - 10'd1;
    pad_calc = (10'(pad_count) > pad_lim) ? pad_lim : 10'(pad_count);
    len_calc = 10'(NN) - 10'(r_calc) - pad_calc;
  end

  always_comb begin
    unique case (cfg_index) inside
      REG_FIELD_POLY, REG_FIRST_ROOT, REG_ROOT_STEP,
      REG_PARITY_CNT, REG_PAD_CNT: cfg_hit = cfg_valid;
      default:                     cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_poly   <= POLY_W'(285);
      first_root   <= '0;
      root_step    <= EXP_W'(1);
      parity_count <= 6'd32;
      pad_count    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FIELD_POLY: field_poly   <= cfg_data;
        REG_FIRST_ROOT: first_root   <= cfg_data[EXP_W-1:0];
        REG_ROOT_STEP:  root_step    <= cfg_data[EXP_W-1:0];
        REG_PARITY_CNT: parity_count <= cfg_data[5:0];
        REG_PAD_CNT:    pad_count    <= cfg_data[7:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_INIT: begin
        eff_roots <= r_calc;
        eff_len   <= len_calc[LEN_W-1:0];
        pow_base  <= M'(2);
        pow_acc   <= M'(1);
        pow_exp   <= root_step;
        for (int j = 0; j < L; j++) begin
          gen[j] <= '0;
          par[j] <= '0;
        end
      end
      OP_POW: begin
        if (pow_exp[0]) pow_acc <= gf_mul(pow_acc, pow_base, poly);
        pow_base <= gf_mul(pow_base, pow_base, poly);
        pow_exp  <= pow_exp >> 1;
      end
      OP_POW_MID: begin
        step_val <= pow_acc;
        pow_base <= pow_acc;
        pow_acc  <= M'(1);
        pow_exp  <= first_root;
      end
      OP_GEN_SET: root_val <= pow_acc;
      OP_GEN: begin
        gen[0] <= gen[0] ^ root_val;
        for (int j = 1; j < L; j++) gen[j] <= gen[j] ^ gf_mul(root_val, gen[j-1], poly);
        root_val <= gf_mul(root_val, step_val, poly);
      end
      OP_ABSORB: begin
        for (int j = 0; j < L - 1; j++) par[j] <= par[j+1] ^ gf_mul(fb, gen[j], poly);
        par[L-1] <= gf_mul(fb, gen[L-1], poly);
      end
      OP_SHIFT: begin
        for (int j = 0; j < L - 1; j++) par[j] <= par[j+1];
        par[L-1] <= '0;
      end
      default: ;
    endcase
  end

  assign status.cfg_hit   = cfg_hit;
  assign status.eff_roots = eff_roots;
  assign status.eff_len   = eff_len;
  assign parity_symbol    = SYM_W'(par[0]);

endmodule

### sv/rse_ctrl.sv
// ----------------------------------------------------------------------------
// rse_ctrl: sequencer of the Reed-Solomon encoder
// Steps the table-free setup, then counts data beats and parity beats.
// ----------------------------------------------------------------------------
module rse_ctrl
  import rse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       sym_valid,
  output logic       sym_ready,
  output logic       par_valid,
  input  logic       par_ready,
  output logic       par_last,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_POW_STEP,
    S_POW_MID,
    S_POW_ROOT,
    S_GEN_SET,
    S_GEN,
    S_RUN,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] sym_cnt;
  logic [CNT_W-1:0] roots_m1;
  logic [CNT_W-1:0] len_m1;

  assign roots_m1  = CNT_W'(status.eff_roots) - CNT_W'(1);
  assign len_m1    = CNT_W'(status.eff_len) - CNT_W'(1);
  assign sym_ready = (state == S_RUN);
  assign par_valid = (state == S_EMIT);
  assign par_last  = (cnt == roots_m1);

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state) inside
      S_INIT:                 cmd.op = OP_INIT;
      S_POW_STEP, S_POW_ROOT: cmd.op = OP_POW;
      S_POW_MID:              cmd.op = OP_POW_MID;
      S_GEN_SET:              cmd.op = OP_GEN_SET;
      S_GEN:                  cmd.op = OP_GEN;
      S_RUN:                  if (sym_valid) cmd.op = OP_ABSORB;
      S_EMIT:                 if (par_ready) cmd.op = OP_SHIFT;
      default:                cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      cnt     <= '0;
      sym_cnt <= '0;
    end else if (status.cfg_hit) begin
      state <= S_INIT;
    end else begin
      unique case (state) inside
        S_INIT: begin
          cnt     <= '0;
          sym_cnt <= '0;
          state   <= S_POW_STEP;
        end
        S_POW_STEP, S_POW_ROOT: begin
          if (cnt == CNT_W'(EXP_W - 1)) begin
            cnt   <= '0;
            state <= (state == S_POW_STEP) ? S_POW_MID : S_GEN_SET;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_POW_MID: state <= S_POW_ROOT;
        S_GEN_SET: begin
          cnt   <= '0;
          state <= S_GEN;
        end
        S_GEN: begin
          if (cnt == roots_m1) begin
            cnt   <= '0;
            state <= S_RUN;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_RUN: begin
          if (sym_valid) begin
            if (sym_cnt == len_m1) begin
              sym_cnt <= '0;
              cnt     <= '0;
              state   <= S_EMIT;
            end else begin
              sym_cnt <= sym_cnt + CNT_W'(1);
            end
          end
        end
        S_EMIT: begin
          if (par_ready) begin
            if (par_last) begin
              cnt   <= '0;
              state <= S_RUN;
            end else begin
              cnt <= cnt + CNT_W'(1);
            end
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

endmodule

### sv/reed_solomon_encoder.sv
// ----------------------------------------------------------------------------
// reed_solomon_encoder: systematic Reed-Solomon parity generator
// Takes data symbols, returns the parity symbols of each codeword.
// ----------------------------------------------------------------------------
// After reset or any register write the block builds the primitive-element
// powers and the generator polynomial; no data beat is taken then, and the
// codeword in progress is dropped. Data beats are absorbed one per cycle,
// while sym_ready is high, by a bank of parallel GF multipliers on the parity
// LFSR. After nn - nroots - pad data beats the nroots parity beats follow,
// one per cycle while par_ready is high, with last on the final one; data is
// held off while parity drains.
module reed_solomon_encoder
  import rse_pkg::*;
#(
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
  parameter int MAX_PARITY  = MAX_PARITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [POLY_W-1:0] cfg_data,
  input  logic              sym_valid,
  output logic              sym_ready,
  input  logic [SYM_W-1:0]  data_symbol,
  output logic              par_valid,
  input  logic              par_ready,
  output logic [SYM_W-1:0]  parity_symbol,
  output logic              last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  rse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .sym_valid (sym_valid),
    .sym_ready (sym_ready),
    .par_valid (par_valid),
    .par_ready (par_ready),
    .par_last  (last),
    .status    (status),
    .cmd       (cmd)
  );

  rse_datapath #(
    .SYMBOL_BITS (SYMBOL_BITS),
    .MAX_PARITY  (MAX_PARITY)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .data_symbol   (data_symbol),
    .cmd           (cmd),
    .status        (status),
    .parity_symbol (parity_symbol)
  );

endmodule

### test/tb_reed_solomon_encoder.sv
// ----------------------------------------------------------------------------
// tb_reed_solomon_encoder: self-checking bench for the Reed-Solomon encoder
// Streams data symbols under several field, root, parity and padding setups,
// predicts every parity beat with its own GF(2^8) LFSR model and compares.
// ----------------------------------------------------------------------------
module tb_reed_solomon_encoder
  import rse_pkg::*;
();

  localparam int NN = 255;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             lst;
  } parity_beat_t;

  class parity_scoreboard;
    int unsigned poly, froot, rstep, pcount, padn;
    logic [7:0] lg [256];
    logic [7:0] alog [256];
    logic [7:0] glog [33];
    logic [7:0] lfsr [32];
    int nroots, cw_len, sym_cnt;
    parity_beat_t pending[$];
    int errors;

    function new();
      poly = 285; froot = 0; rstep = 1; pcount = 32; padn = 0;
      errors = 0;
      rebuild();
    endfunction

    function logic [7:0] scale(logic [7:0] v, int unsigned e);
      if (v == 0) return 0;
      return alog[(lg[v] + e) % NN];
    endfunction

    function void rebuild();
      int unsigned sr, root, step, pad;
      logic [7:0] g [33];
      sr = 1;
      for (int i = 0; i < 256; i++) begin
        lg[i] = 0; alog[i] = 0;
      end
      for (int i = 0; i < NN; i++) begin
        lg[sr & 8'hff] = i[7:0];
        alog[i] = sr[7:0];
        sr = sr << 1;
        if (sr & 256) sr = sr ^ poly;
        sr = sr & NN;
      end
      lg[0] = 8'(NN);
      alog[NN] = 0;
      nroots = pcount;
      if (nroots < 1) nroots = 1;
      if (nroots > 32) nroots = 32;
      pad = padn;
      if (pad > NN - nroots - 1) pad = NN - nroots - 1;
      cw_len = NN - nroots - pad;
      step = rstep % NN;
      root = ((froot % NN) * step) % NN;
      for (int i = 0; i < 33; i++) g[i] = 0;
      g[0] = 1;
      for (int i = 0; i < nroots; i++) begin
        g[i+1] = 1;
        for (int j = i; j > 0; j--) g[j] = g[j-1] ^ scale(g[j], root);
        g[0] = scale(g[0], root);
        root = (root + step) % NN;
      end
      for (int i = 0; i < 33; i++) glog[i] = (i <= nroots) ? lg[g[i]] : 8'd0;
      for (int i = 0; i < 32; i++) lfsr[i] = 0;
      sym_cnt = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [POLY_W-1:0] val);
      case (idx)
        REG_FIELD_POLY: poly = val;
        REG_FIRST_ROOT: froot = val[7:0];
        REG_ROOT_STEP:  rstep = val[7:0];
        REG_PARITY_CNT: pcount = val[5:0];
        REG_PAD_CNT:    padn = val[7:0];
        default: return;
      endcase
      rebuild();
    endfunction

    function logic [7:0] term(int unsigned fl, logic [7:0] gl);
      if (gl == NN) return 0;
      return alog[(fl + gl) % NN];
    endfunction

    function void note_symbol(logic [7:0] d);
      logic [7:0] fb;
      int unsigned fl;
      parity_beat_t b;
      fb = d ^ lfsr[0];
      fl = lg[fb];
      if (fb != 0)
        for (int j = 0; j < nroots; j++) lfsr[j] ^= term(fl, glog[nroots-j]);
      for (int j = 0; j < nroots - 1; j++) lfsr[j] = lfsr[j+1];
      lfsr[nroots-1] = (fb != 0) ? term(fl, glog[0]) : 8'd0;
      sym_cnt++;
      if (sym_cnt < cw_len) return;
      for (int j = 0; j < nroots; j++) begin
        b.sym = lfsr[j];
        b.lst = (j == nroots - 1);
        pending.push_back(b);
      end
      for (int j = 0; j < 32; j++) lfsr[j] = 0;
      sym_cnt = 0;
    endfunction

    function void check_parity(logic [7:0] sym, logic lst);
      parity_beat_t e;
      if (pending.size() == 0) begin
        $error("parity beat with nothing expected: %0h", sym);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (sym !== e.sym) begin
        $error("parity_symbol expected %0h actual %0h", e.sym, sym);
        errors++;
      end
      if (lst !== e.lst) begin
        $error("last expected %0b actual %0b", e.lst, lst);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [IDX_W-1:0] cfg_index = 0;
  logic [POLY_W-1:0] cfg_data = 0;
  logic sym_valid = 0, sym_ready;
  logic [SYM_W-1:0] data_symbol = 0;
  logic par_valid, par_ready = 0;
  logic [SYM_W-1:0] parity_symbol;
  logic last;

  parity_scoreboard sb = new();
  int idle_pct = 6;
  int quiet_cycles = 0;

  reed_solomon_encoder DUT (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && par_valid && par_ready) sb.check_parity(parity_symbol, last);
    if ((sym_valid && sym_ready) || (par_valid && par_ready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) par_ready <= ($urandom_range(99) >= idle_pct);

  task automatic send_symbol(logic [7:0] d);
    while ($urandom_range(99) < idle_pct) begin
      sym_valid <= 0;
      @(negedge clk);
    end
    sym_valid <= 1;
    data_symbol <= d;
    @(posedge clk);
    while (!sym_ready) @(posedge clk);
    sb.note_symbol(d);
    @(negedge clk);
  endtask

  task automatic drain();
    sym_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic [IDX_W-1:0] idx, logic [POLY_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic setup(int unsigned p, int unsigned fr, int unsigned st,
                       int unsigned pc, int unsigned pd);
    drain();
    write_cfg(REG_FIELD_POLY, POLY_W'(p));
    write_cfg(REG_FIRST_ROOT, POLY_W'(fr));
    write_cfg(REG_ROOT_STEP, POLY_W'(st));
    write_cfg(REG_PARITY_CNT, POLY_W'(pc));
    write_cfg(REG_PAD_CNT, POLY_W'(pd));
    cfg_valid <= 0;
  endtask

  task automatic random_codewords(int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      send_symbol($urandom_range(3) == 0 ? ($urandom_range(1) ? 8'hff : 8'h00)
                                         : 8'($urandom));
      sent++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // reset config: full-length codeword, 32 roots; directed extremes
    send_symbol(8'h00); send_symbol(8'hff); send_symbol(8'h01); send_symbol(8'h80);
    for (int i = 4; i < 223; i++) send_symbol(8'($urandom));
    // max pad, single parity, zero step, alternate primitive polynomial
    setup(9'h12d, 255, 0, 1, 255);
    for (int i = 0; i < 20; i++) send_symbol(i[0] ? 8'hff : 8'h00);
    setup(285, 0, 1, 32, 222);
    idle_pct = 0;
    random_codewords(40);
    idle_pct = 6;
    setup(9'h169, 255, 255, 0, 200);
    random_codewords(40);
    setup(285, 1, 7, 63, 215);
    random_codewords(40);
    drain();
    setup(9'h187, 120, 3, 16, 210);
    random_codewords(58);
    setup(285, 0, 1, 2, 240);
    random_codewords(40);
    drain();
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
